>>> sv/ssdc_pkg.sv
// Package for the speed/steer drive controller.
// Holds register indexes, field widths and the delay-line tap record.
// No dependencies.
package ssdc_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned MagCfgW   = 31;
  localparam int unsigned DeadbandW = 16;
  localparam int unsigned DelayCfgW = 7;
  localparam int unsigned CfgAddrW  = 3;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_ACCEL_GAIN     = 3'd0,
    CFG_ACCEL_LIM      = 3'd1,
    CFG_MAX_DECEL      = 3'd2,
    CFG_MAX_STEER_RATE = 3'd3,
    CFG_STEER_DEADBAND = 3'd4,
    CFG_DELAY_LENGTH   = 3'd5
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [MagCfgW-1:0]   AccelGainRst    = 31'd65536;
  localparam logic [MagCfgW-1:0]   AccelLimRst     = 31'd589824;
  localparam logic [MagCfgW-1:0]   MaxDecelRst     = 31'd589824;
  localparam logic [MagCfgW-1:0]   MaxSteerRateRst = 31'd211026;
  localparam logic [DeadbandW-1:0] SteerDeadbandRst = 16'd7;
  localparam logic [DelayCfgW-1:0] DelayLengthRst  = 7'd0;

  // Registered read of the delay line, available in the cycle after the beat
  typedef struct packed {
    logic [DataW-1:0] data;  // entry written delay_length beats ago
    logic             pass;  // zero delay: use the beat's own target
    logic             hit;   // entry has been written since reset
  } tap_t;

endpackage

>>> sv/ssdc_delay_line.sv
// Steering target delay line: one synchronous memory, write pointer and fill count.
// Reads the delayed entry and writes the new one in the same cycle.
// Depends on ssdc_pkg.
module ssdc_delay_line #(
  parameter int unsigned DELAY_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                wr_i,
  input  logic [ssdc_pkg::DataW-1:0]          wr_data_i,
  input  logic [ssdc_pkg::DelayCfgW-1:0]      delay_len_i,
  output ssdc_pkg::tap_t                      tap_o
);
  import ssdc_pkg::*;

  localparam int unsigned AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned LW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned CW = (LW > DelayCfgW) ? LW : DelayCfgW;

  logic [DataW-1:0] mem [DELAY_DEPTH];
  logic [DataW-1:0] rd_q;
  logic             pass_q;
  logic             hit_q;
  logic [AW-1:0]    wp_q;
  logic [LW-1:0]    fill_q;

  logic [CW-1:0]    len_ext;
  logic [CW-1:0]    len_sat;
  logic [LW-1:0]    len_l;
  logic [LW:0]      wp_ext;
  logic [LW:0]      rp_full;
  logic [AW-1:0]    rd_addr;

  // Saturate the delay to the depth of the store
  assign len_ext = CW'(delay_len_i);
  assign len_sat = (len_ext > CW'(DELAY_DEPTH)) ? CW'(DELAY_DEPTH) : len_ext;
  assign len_l   = len_sat[LW-1:0];

  // Read address: write pointer minus delay, modulo depth
  assign wp_ext = (LW + 1)'(wp_q);
  always_comb begin
    if (wp_ext >= (LW + 1)'(len_l)) begin
      rp_full = wp_ext - (LW + 1)'(len_l);
    end else begin
      rp_full = wp_ext + (LW + 1)'(DELAY_DEPTH) - (LW + 1)'(len_l);
    end
  end
  assign rd_addr = rp_full[AW-1:0];

  // Memory: read returns old data when read and write hit the same entry
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wp_q] <= wr_data_i;
    end
    if (en_i) begin
      rd_q   <= mem[rd_addr];
      pass_q <= (len_l == '0);
      hit_q  <= (fill_q >= len_l);
    end
  end

  // Write pointer and fill count; fill count stands in for clearing the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (wr_i) begin
      if (wp_q == AW'(DELAY_DEPTH - 1)) begin
        wp_q <= '0;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
      if (fill_q != LW'(DELAY_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign tap_o.data = rd_q;
  assign tap_o.pass = pass_q;
  assign tap_o.hit  = hit_q;

endmodule

>>> sv/ssdc_accel_path.sv
// Acceleration path: speed error, gain multiply, saturation and brake select.
// Two register stages; the result is combinational off the second stage.
// Depends on ssdc_pkg.
module ssdc_accel_path (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ssdc_pkg::DataW-1:0] desired_speed_i,
  input  logic signed [ssdc_pkg::DataW-1:0] current_velocity_i,
  input  logic [ssdc_pkg::MagCfgW-1:0]      accel_gain_i,
  input  logic [ssdc_pkg::MagCfgW-1:0]      accel_lim_i,
  input  logic [ssdc_pkg::MagCfgW-1:0]      max_decel_i,
  output logic signed [ssdc_pkg::DataW-1:0] accel_o
);
  import ssdc_pkg::*;

  localparam int unsigned ProdW = DataW + MagCfgW;

  typedef enum logic [1:0] {
    ACC_PROP      = 2'd0,
    ACC_BRAKE_NEG = 2'd1,
    ACC_BRAKE_POS = 2'd2
  } accel_mode_e;

  logic [DataW:0]        err;
  logic [DataW:0]        err_abs;
  logic                  err_neg;
  logic                  err_pos;
  logic                  vel_pos;
  logic                  vel_neg;
  accel_mode_e           mode_d;

  logic [DataW-1:0]      mag_q;
  logic                  neg_a_q;
  accel_mode_e           mode_a_q;
  logic [ProdW-1:0]      prod_q;
  logic                  neg_b_q;
  accel_mode_e           mode_b_q;

  logic [ProdW-17:0]     scaled;
  logic [MagCfgW-1:0]    sat;
  logic [DataW-1:0]      prop;

  // Speed error, exact in 33 bits; its magnitude fits 32 bits
  assign err     = {desired_speed_i[DataW-1], desired_speed_i}
                 - {current_velocity_i[DataW-1], current_velocity_i};
  assign err_neg = err[DataW];
  assign err_pos = !err[DataW] && (|err);
  assign err_abs = err_neg ? (~err + 1'b1) : err;
  assign vel_neg = current_velocity_i[DataW-1];
  assign vel_pos = !current_velocity_i[DataW-1] && (|current_velocity_i);

  // Brake when the error opposes the motion, or is zero while moving forward
  always_comb begin
    if (vel_pos) begin
      mode_d = err_pos ? ACC_PROP : ACC_BRAKE_NEG;
    end else if (vel_neg) begin
      mode_d = err_pos ? ACC_BRAKE_POS : ACC_PROP;
    end else begin
      mode_d = ACC_PROP;
    end
  end

  // Stage A: error magnitude; stage B: gain product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= err_abs[DataW-1:0];
      neg_a_q  <= err_neg;
      mode_a_q <= mode_d;
      prod_q   <= ProdW'(mag_q) * ProdW'(accel_gain_i);
      neg_b_q  <= neg_a_q;
      mode_b_q <= mode_a_q;
    end
  end

  // Q31.32 back to Q16.16 by truncation, then saturate and sign
  assign scaled = prod_q[ProdW-1:16];
  assign sat    = (scaled > (ProdW - 16)'(accel_lim_i)) ? accel_lim_i
                                                       : scaled[MagCfgW-1:0];
  assign prop   = neg_b_q ? (~{1'b0, sat} + 1'b1) : {1'b0, sat};

  always_comb begin
    case (mode_b_q)
      ACC_PROP:      accel_o = prop;
      ACC_BRAKE_NEG: accel_o = ~{1'b0, max_decel_i} + 1'b1;
      ACC_BRAKE_POS: accel_o = {1'b0, max_decel_i};
      default:       accel_o = prop;
    endcase
  end

endmodule

>>> sv/speed_steer_drive_controller.sv
// Speed/steer drive controller top level.
// An accepted input beat passes the delay-line read, the gain product and the output register before its result beat.
// Throughput: one beat per cycle while the output is not stalled; the delay-line memory reads and writes once per beat.
// Reset: configuration returns to defaults, pipeline empties, delay line reads as
// zero until written (tracked by a fill count, no clearing pass).
// Depends on ssdc_pkg, ssdc_delay_line, ssdc_accel_path.
module speed_steer_drive_controller #(
  parameter int unsigned DELAY_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ssdc_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [ssdc_pkg::MagCfgW-1:0]        cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ssdc_pkg::DataW-1:0]   desired_speed_i,
  input  logic signed [ssdc_pkg::DataW-1:0]   desired_steer_i,
  input  logic signed [ssdc_pkg::DataW-1:0]   current_velocity_i,
  input  logic signed [ssdc_pkg::DataW-1:0]   current_steer_angle_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ssdc_pkg::DataW-1:0]   accel_command_o,
  output logic signed [ssdc_pkg::DataW-1:0]   steer_rate_command_o
);
  import ssdc_pkg::*;

  logic [MagCfgW-1:0]   accel_gain_q;
  logic [MagCfgW-1:0]   accel_lim_q;
  logic [MagCfgW-1:0]   max_decel_q;
  logic [MagCfgW-1:0]   max_steer_rate_q;
  logic [DeadbandW-1:0] steer_deadband_q;
  logic [DelayCfgW-1:0] delay_length_q;

  logic                 adv;
  logic                 accept;
  tap_t                 tap;

  logic                 v1_q;
  logic                 v2_q;
  logic                 out_valid_q;
  logic [DataW-1:0]     dsteer1_q;
  logic [DataW-1:0]     ang1_q;
  logic [DataW-1:0]     rate2_q;
  logic [DataW-1:0]     rate_d;
  logic [DataW-1:0]     target;
  logic [DataW:0]       aerr;
  logic [DataW:0]       db_pos;
  logic [DataW:0]       db_neg;
  logic [DataW-1:0]     accel_d;
  logic [DataW-1:0]     accel_q;
  logic [DataW-1:0]     rate_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q     <= AccelGainRst;
      accel_lim_q      <= AccelLimRst;
      max_decel_q      <= MaxDecelRst;
      max_steer_rate_q <= MaxSteerRateRst;
      steer_deadband_q <= SteerDeadbandRst;
      delay_length_q   <= DelayLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ACCEL_GAIN:     accel_gain_q     <= cfg_wdata_i;
        CFG_ACCEL_LIM:      accel_lim_q      <= cfg_wdata_i;
        CFG_MAX_DECEL:      max_decel_q      <= cfg_wdata_i;
        CFG_MAX_STEER_RATE: max_steer_rate_q <= cfg_wdata_i;
        CFG_STEER_DEADBAND: steer_deadband_q <= cfg_wdata_i[DeadbandW-1:0];
        CFG_DELAY_LENGTH:   delay_length_q   <= cfg_wdata_i[DelayCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output register holds a stalled beat
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  ssdc_delay_line #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .wr_i        (accept),
    .wr_data_i   (desired_steer_i),
    .delay_len_i (delay_length_q),
    .tap_o       (tap)
  );

  ssdc_accel_path u_accel (
    .clk_i              (clk_i),
    .en_i               (adv),
    .desired_speed_i    (desired_speed_i),
    .current_velocity_i (current_velocity_i),
    .accel_gain_i       (accel_gain_q),
    .accel_lim_i        (accel_lim_q),
    .max_decel_i        (max_decel_q),
    .accel_o            (accel_d)
  );

  // Steer rate from delayed target against measured angle
  always_comb begin
    if (tap.pass) begin
      target = dsteer1_q;
    end else if (tap.hit) begin
      target = tap.data;
    end else begin
      target = '0;
    end
  end

  assign aerr   = {target[DataW-1], target} - {ang1_q[DataW-1], ang1_q};
  assign db_pos = (DataW + 1)'(steer_deadband_q);
  assign db_neg = ~db_pos + 1'b1;

  always_comb begin
    if ($signed(aerr) > $signed(db_pos)) begin
      rate_d = {1'b0, max_steer_rate_q};
    end else if ($signed(aerr) < $signed(db_neg)) begin
      rate_d = ~{1'b0, max_steer_rate_q} + 1'b1;
    end else begin
      rate_d = '0;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsteer1_q <= desired_steer_i;
      ang1_q    <= current_steer_angle_i;
      rate2_q   <= rate_d;
      accel_q   <= accel_d;
      rate_q    <= rate2_q;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign accel_command_o      = accel_q;
  assign steer_rate_command_o = rate_q;

  // Steer rate is always zero or the configured magnitude with either sign
  a_rate_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (steer_rate_command_o == '0 ||
                     steer_rate_command_o == {1'b0, max_steer_rate_q} ||
                     steer_rate_command_o == ~{1'b0, max_steer_rate_q} + 1'b1))
    else $error("steer rate outside its three levels");

  // A positive command never exceeds both bounds
  a_accel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accel_command_o[DataW-1]) |->
      (accel_command_o[MagCfgW-1:0] <= accel_lim_q ||
       accel_command_o == {1'b0, max_decel_q}))
    else $error("acceleration command above its bound");

  // A beat in the product stage reaches the output once the pipeline moves
  a_pipe_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !in_stall_o) |=> out_valid_o)
    else $error("beat lost between product stage and output");

endmodule

>>> bench/tb_speed_steer_drive_controller.sv
// Self-checking bench for speed_steer_drive_controller: control ticks in, accel and steer-rate
// commands out, each result checked against an in-bench prediction of the controller.
// Depends on ssdc_pkg and the speed_steer_drive_controller RTL.
module tb_speed_steer_drive_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import ssdc_pkg::*;

  localparam int unsigned HistDepth = 64;
  localparam int unsigned TickLimit = 400_000;
  localparam logic [CfgAddrW-1:0] CfgUnusedIdx = 3'd6;
  localparam logic [31:0] FixMax = 32'h7FFF_FFFF;
  localparam logic [31:0] FixMin = 32'h8000_0000;

  // One control tick and the two commands it produces
  typedef struct packed {
    logic [31:0] dspeed;
    logic [31:0] dsteer;
    logic [31:0] vel;
    logic [31:0] ang;
  } tick_t;

  typedef struct packed {
    logic [31:0] accel;
    logic [31:0] rate;
  } cmd_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0]      cfg_addr_i = '0;
  logic [MagCfgW-1:0]       cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DataW-1:0]  desired_speed_i = '0;
  logic signed [DataW-1:0]  desired_steer_i = '0;
  logic signed [DataW-1:0]  current_velocity_i = '0;
  logic signed [DataW-1:0]  current_steer_angle_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DataW-1:0]  accel_command_o;
  logic signed [DataW-1:0]  steer_rate_command_o;

  // Bench-side copy of the configuration and the steering history
  logic [MagCfgW-1:0]   gain_r, amax_r, dmax_r, rate_r;
  logic [DeadbandW-1:0] dband_r;
  logic [DelayCfgW-1:0] dly_r;
  logic [31:0]          steer_hist [HistDepth];
  logic [5:0]           hist_wp;

  tick_t       pending_ticks [$];
  cmd_t        cmd_expect_q [$];
  int unsigned fail_cnt = 0;
  int unsigned tick_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          in_took = 1'b0;
  bit          calm_run = 1'b0;

  speed_steer_drive_controller #(
    .DELAY_DEPTH(HistDepth)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .desired_speed_i      (desired_speed_i),
    .desired_steer_i      (desired_steer_i),
    .current_velocity_i   (current_velocity_i),
    .current_steer_angle_i(current_steer_angle_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .accel_command_o      (accel_command_o),
    .steer_rate_command_o (steer_rate_command_o)
  );

  always #6 clk_i = ~clk_i;

  // Gain times |error|, Q16.16, clipped to the accel limit, sign of the error restored
  function automatic longint prop_accel(input longint err);
    longint unsigned mag, prod;
    mag = (err < 0) ? longint'(-err) : longint'(err);
    prod = (mag * 64'(gain_r)) >> 16;
    if (prod > 64'(amax_r)) prod = 64'(amax_r);
    return (err < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // Commands for one tick; advances the steering history
  function automatic cmd_t calc_drive_cmds(input tick_t t);
    cmd_t        c;
    longint      serr, aerr, vel, acc, rt, target;
    int unsigned dly;
    logic [5:0]  rp;
    dly = (dly_r > HistDepth) ? HistDepth : dly_r;
    if (dly == 0) begin
      target = longint'($signed(t.dsteer));
    end else begin
      rp = hist_wp - 6'(dly);
      target = longint'($signed(steer_hist[rp]));
    end
    steer_hist[hist_wp] = t.dsteer;
    hist_wp = hist_wp + 6'd1;

    vel = longint'($signed(t.vel));
    serr = longint'($signed(t.dspeed)) - vel;
    if (vel > 0) begin
      acc = (serr > 0) ? prop_accel(serr) : -longint'(dmax_r);
    end else if (vel < 0) begin
      acc = (serr > 0) ? longint'(dmax_r) : prop_accel(serr);
    end else begin
      acc = prop_accel(serr);
    end

    aerr = target - longint'($signed(t.ang));
    if (aerr > longint'(dband_r)) rt = longint'(rate_r);
    else if (aerr < -longint'(dband_r)) rt = -longint'(rate_r);
    else rt = 0;

    c.accel = acc[31:0];
    c.rate = rt[31:0];
    return c;
  endfunction

  // Mostly short gaps, some long ones; none during a calm phase
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (calm_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Field values: extremes, full range, and small values near zero
  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return FixMin;
          1: return FixMax;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return 32'($urandom_range(0, 32'h8_0000) - 32'h4_0000);
    endcase
  endfunction

  function automatic logic [MagCfgW-1:0] pick_cfg(input int unsigned hi);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return MagCfgW'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic void add_tick(input logic [31:0] s, st, v, a);
    tick_t t;
    t.dspeed = s;
    t.dsteer = st;
    t.vel = v;
    t.ang = a;
    pending_ticks.insert(pending_ticks.size(), t);
  endfunction

  function automatic void add_random_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) add_tick(rand_fix(), rand_fix(), rand_fix(), rand_fix());
  endfunction

  // Register write, mirrored into the bench copy once it has landed
  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [MagCfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      CFG_ACCEL_GAIN:     gain_r = val;
      CFG_ACCEL_LIM:      amax_r = val;
      CFG_MAX_DECEL:      dmax_r = val;
      CFG_MAX_STEER_RATE: rate_r = val;
      CFG_STEER_DEADBAND: dband_r = val[DeadbandW-1:0];
      CFG_DELAY_LENGTH:   dly_r = val[DelayCfgW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [MagCfgW-1:0] g, am, dm, rt, db, dl);
    write_reg(CFG_ACCEL_GAIN, g);
    write_reg(CFG_ACCEL_LIM, am);
    write_reg(CFG_MAX_DECEL, dm);
    write_reg(CFG_MAX_STEER_RATE, rt);
    write_reg(CFG_STEER_DEADBAND, db);
    write_reg(CFG_DELAY_LENGTH, dl);
  endtask

  // Sender holds off until every queued tick is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || cmd_expect_q.size() != 0);
  endtask

  // Input driver and output stall, both on the falling edge
  always @(negedge clk_i) begin
    tick_t nxt;
    if (!in_valid_i || in_took) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_ticks.size() > 0) begin
        nxt = pending_ticks.pop_front();
        desired_speed_i <= nxt.dspeed;
        desired_steer_i <= nxt.dsteer;
        current_velocity_i <= nxt.vel;
        current_steer_angle_i <= nxt.ang;
        in_valid_i <= 1'b1;
        in_gap = pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
      out_hold = pick_idle();
    end
  end

  // Beat monitor: predict on input beats, check on output beats
  always @(posedge clk_i) begin
    tick_t cur;
    cmd_t  want;
    tick_count++;
    if (tick_count > TickLimit) begin
      $display("speed_steer_drive_controller test failed");
      $finish;
    end else begin
      in_took = in_valid_i && !in_stall_o;
      if (rst_ni && in_took) begin
        cur.dspeed = desired_speed_i;
        cur.dsteer = desired_steer_i;
        cur.vel = current_velocity_i;
        cur.ang = current_steer_angle_i;
        cmd_expect_q.insert(cmd_expect_q.size(), calc_drive_cmds(cur));
      end
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (cmd_expect_q.size() == 0) begin
          $error("unexpected result beat: accel_command %0d steer_rate_command %0d",
                 accel_command_o, steer_rate_command_o);
          fail_cnt++;
        end else begin
          want = cmd_expect_q.pop_front();
          if (accel_command_o !== want.accel) begin
            $error("accel_command: expected %0d, actual %0d", $signed(want.accel),
                   accel_command_o);
            fail_cnt++;
          end
          if (steer_rate_command_o !== want.rate) begin
            $error("steer_rate_command: expected %0d, actual %0d", $signed(want.rate),
                   steer_rate_command_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    logic [DelayCfgW-1:0] dl;
    gain_r = AccelGainRst;
    amax_r = AccelLimRst;
    dmax_r = MaxDecelRst;
    rate_r = MaxSteerRateRst;
    dband_r = SteerDeadbandRst;
    dly_r = DelayLengthRst;
    hist_wp = '0;
    for (int i = 0; i < HistDepth; i++) steer_hist[i] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Longest delay straight after reset: the first 64 ticks see a zero target
    write_reg(CFG_DELAY_LENGTH, MagCfgW'(HistDepth));
    add_random_ticks(70);
    wait_drained();

    // Reset gains, zero delay: directed corners
    write_reg(CFG_DELAY_LENGTH, '0);
    add_tick('0, '0, '0, '0);
    add_tick(FixMax, '0, FixMin, '0);           // reversing, error forward: brake
    add_tick(FixMin, '0, FixMax, '0);           // forward, error backward: brake
    add_tick(FixMax, '0, '0, '0);               // standing, saturates positive
    add_tick(FixMin, '0, '0, '0);               // standing, saturates negative
    add_tick(32'h3_0000, 32'd5, 32'h1_0000, 32'd5);
    add_tick(-32'sh3_0000, '0, -32'sh1_0000, '0);
    add_tick(32'h1_0000, '0, 32'h1_0000, '0);   // forward, zero error: brake
    add_tick(-32'sh1_0000, '0, -32'sh1_0000, '0);
    add_tick('0, 32'h1007, '0, 32'h1000);       // on the deadband edge
    add_tick('0, 32'h1008, '0, 32'h1000);
    add_tick('0, 32'h0FF9, '0, 32'h1000);
    add_tick('0, 32'h0FF8, '0, 32'h1000);
    add_tick('0, FixMax, '0, FixMin);
    add_tick('0, FixMin, '0, FixMax);
    add_tick('1, '1, '1, '1);
    add_tick(FixMin, FixMin, FixMin, FixMin);
    add_tick(FixMax, FixMax, FixMax, FixMax);
    add_tick(32'd1, '0, '1, '0);
    add_tick('1, '0, 32'd1, '0);
    add_random_ticks(40);
    wait_drained();

    // Everything zero but the delay length, set to 1; no idling on either side
    calm_run = 1'b1;
    write_all_regs('0, '0, '0, '0, '0, MagCfgW'(1));
    add_random_ticks(60);
    wait_drained();
    calm_run = 1'b0;

    // Everything at full scale; delay and deadband get wider data than they hold
    write_all_regs('1, '1, '1, '1, '1, '1);
    add_random_ticks(60);
    wait_drained();

    // Random settings; the history is not cleared across delay changes
    for (int unsigned ph = 0; ph < 6; ph++) begin
      calm_run = (ph == 2);
      if (ph == 1) write_reg(CfgUnusedIdx, MagCfgW'($urandom));
      case (ph)
        0: dl = 7'd63;
        1: dl = 7'd1;
        default: dl = DelayCfgW'($urandom_range(0, HistDepth));
      endcase
      write_all_regs(pick_cfg(32'h10_0000), pick_cfg(32'h40_0000), pick_cfg(32'h40_0000),
                     pick_cfg(32'h7FFF_FFFF), MagCfgW'($urandom_range(0, 65535)),
                     MagCfgW'(dl));
      add_random_ticks(65);
      wait_drained();
    end
    calm_run = 1'b0;

    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) $display("speed_steer_drive_controller test passed");
    else $display("speed_steer_drive_controller test failed");
    $finish;
  end

endmodule

>>> sim.f
sv/ssdc_pkg.sv
sv/ssdc_delay_line.sv
sv/ssdc_accel_path.sv
sv/speed_steer_drive_controller.sv
bench/tb_speed_steer_drive_controller.sv
